// ===== hdl/mlp_pkg.sv =====
// shared types and constants for the 4-5-1 leaky relu perceptron
`default_nettype none
package mlp_pkg;

  // network shape and number format
  localparam int HIDDEN_COUNT = 5;
  localparam int FRAC_BITS    = 12;
  localparam int NET_INPUTS   = 4;
  localparam int NEURON_W     = NET_INPUTS + 1;
  localparam int OUT_BASE     = HIDDEN_COUNT * NEURON_W;
  localparam int WEIGHT_COUNT = OUT_BASE + HIDDEN_COUNT + 1;

  // field widths
  localparam int Q_W   = 16;
  localparam int IDX_W = 5;
  localparam int SUM_W = 40;

  // internal widths
  localparam int PROD_W     = 2 * Q_W;
  localparam int HSUM_W     = PROD_W + $clog2(NEURON_W);
  localparam int OSUM_W     = PROD_W + $clog2(HIDDEN_COUNT + 1);
  localparam int LEAK_MUL_W = 11;
  localparam int LEAKP_W    = HSUM_W + LEAK_MUL_W;

  // leaky relu slope, about 0.01 in q0.16
  localparam int LEAK_MUL   = 655;
  localparam int LEAK_SHIFT = 16;

  localparam int Q_MAX = 32767;
  localparam int Q_MIN = -32768;

  // cycles from accepted transaction to result strobe
  localparam int LATENCY = 6;

  // operation codes carried by the mode field
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [HSUM_W-1:0] hsum_t;
  typedef logic signed [OSUM_W-1:0] osum_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // a weight write traveling down the pipe
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    q_t               val;
  } wr_t;

endpackage
`default_nettype wire

// ===== hdl/mlp_4_5_1_leaky_relu_eval.sv =====
// top level: pipelined forward pass of the 4-5-1 leaky relu perceptron
//
// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------------
// command   | start / busy       | mode, weight_index, weight_value,
//           |                    | in_height, in_distance, in_velocity,
//           |                    | in_center_offset
// result    | done (one cycle)   | activation_sum, fires
//
// one transaction is taken in every cycle; busy is high only during reset
// an evaluation gives its result once it has passed the six register
// stages: input products, hidden sums, leak multiply, hidden clamp,
// output products, output sum
// a weight write gives no result; writes to output weights ride the pipe and
// land when they reach the output product stage, so ordering is kept
// rst is synchronous and clears all valid bits; the receiver cannot stall
`default_nettype none
module mlp_4_5_1_leaky_relu_eval (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire                           mode,
  input  wire [mlp_pkg::IDX_W-1:0]      weight_index,
  input  wire signed [mlp_pkg::Q_W-1:0] weight_value,
  input  wire signed [mlp_pkg::Q_W-1:0] in_height,
  input  wire signed [mlp_pkg::Q_W-1:0] in_distance,
  input  wire signed [mlp_pkg::Q_W-1:0] in_velocity,
  input  wire signed [mlp_pkg::Q_W-1:0] in_center_offset,
  output logic                          done,
  output logic signed [mlp_pkg::SUM_W-1:0] activation_sum,
  output logic                          fires
);

  localparam int H = mlp_pkg::HIDDEN_COUNT;
  localparam int N = mlp_pkg::NET_INPUTS;

  // accept logic
  logic accept;
  logic eval_acc;
  logic wr_acc;

  assign busy     = rst;
  assign accept   = start && !busy;
  assign eval_acc = accept && (mode == mlp_pkg::MODE_EVAL);
  assign wr_acc   = accept && (mode == mlp_pkg::MODE_WRITE);

  // network inputs in order
  mlp_pkg::q_t x [N];
  assign x[0] = in_height;
  assign x[1] = in_distance;
  assign x[2] = in_velocity;
  assign x[3] = in_center_offset;

  // weight stores: hidden weights are read at accept, output weights at stage 4
  mlp_pkg::q_t w_hid [mlp_pkg::OUT_BASE];
  mlp_pkg::q_t w_out [H+1];

  // write bundles traveling with the pipe, up to the output weight read point
  mlp_pkg::wr_t wr_in;
  mlp_pkg::wr_t w1, w2, w3, w4;

  assign wr_in.en  = wr_acc;
  assign wr_in.idx = weight_index;
  assign wr_in.val = weight_value;

  // evaluation valid bits
  logic v1, v2, v3, v4, v5, v6;

  // stage registers
  mlp_pkg::prod_t prod1 [H][N];
  mlp_pkg::q_t    bias1 [H];
  mlp_pkg::hsum_t h2    [H];
  mlp_pkg::hsum_t h3    [H];
  mlp_pkg::q_t    hv4   [H];
  mlp_pkg::prod_t op5   [H];
  mlp_pkg::q_t    ob5;

  // control pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      w1.en <= 1'b0;
      w2.en <= 1'b0;
      w3.en <= 1'b0;
      w4.en <= 1'b0;
    end else begin
      v1 <= eval_acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      w1.en <= wr_in.en;
      w2.en <= w1.en;
      w3.en <= w2.en;
      w4.en <= w3.en;
    end
    // write payload travels without reset
    w1.idx <= wr_in.idx;
    w1.val <= wr_in.val;
    w2.idx <= w1.idx;
    w2.val <= w1.val;
    w3.idx <= w2.idx;
    w3.val <= w2.val;
    w4.idx <= w3.idx;
    w4.val <= w3.val;
  end

  // hidden weight store, written at accept
  always_ff @(posedge clk) begin
    for (int e = 0; e < mlp_pkg::OUT_BASE; e++) begin
      if (wr_in.en && int'(wr_in.idx) == e) begin
        w_hid[e] <= wr_in.val;
      end
    end
  end

  // output weight store, written when the write reaches stage 4
  always_ff @(posedge clk) begin
    for (int e = 0; e <= H; e++) begin
      if (w4.en && int'(w4.idx) == mlp_pkg::OUT_BASE + e) begin
        w_out[e] <= w4.val;
      end
    end
  end

  // stage 1: input times weight for every hidden neuron
  always_ff @(posedge clk) begin
    for (int k = 0; k < H; k++) begin
      for (int i = 0; i < N; i++) begin
        prod1[k][i] <= mlp_pkg::prod_t'(x[i]) *
                       mlp_pkg::prod_t'(w_hid[k*mlp_pkg::NEURON_W + i]);
      end
      bias1[k] <= w_hid[k*mlp_pkg::NEURON_W + N];
    end
  end

  // stage 2: hidden sums with the bias scaled up to q.2f
  mlp_pkg::hsum_t hsum [H];
  always_comb begin
    for (int k = 0; k < H; k++) begin
      hsum[k] = mlp_pkg::hsum_t'(bias1[k]) <<< mlp_pkg::FRAC_BITS;
      for (int i = 0; i < N; i++) begin
        hsum[k] = hsum[k] + mlp_pkg::hsum_t'(prod1[k][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < H; k++) begin
      h2[k] <= hsum[k];
    end
  end

  // stage 3: leaky relu, negative sums scaled by 655/2^16 (floor)
  localparam logic signed [mlp_pkg::LEAK_MUL_W-1:0] LeakK =
    mlp_pkg::LEAK_MUL_W'(mlp_pkg::LEAK_MUL);

  logic signed [mlp_pkg::LEAKP_W-1:0] leak_p [H];
  logic signed [mlp_pkg::LEAKP_W-1:0] leak_s [H];
  mlp_pkg::hsum_t                     leak_v [H];
  always_comb begin
    for (int k = 0; k < H; k++) begin
      leak_p[k] = mlp_pkg::LEAKP_W'(h2[k]) * mlp_pkg::LEAKP_W'(LeakK);
      leak_s[k] = leak_p[k] >>> mlp_pkg::LEAK_SHIFT;
      leak_v[k] = h2[k][mlp_pkg::HSUM_W-1] ? leak_s[k][mlp_pkg::HSUM_W-1:0] : h2[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < H; k++) begin
      h3[k] <= leak_v[k];
    end
  end

  // stage 4: back to q4.12 with floor, saturated to 16 bits
  mlp_pkg::hsum_t hsh [H];
  mlp_pkg::q_t    hsat [H];
  always_comb begin
    for (int k = 0; k < H; k++) begin
      hsh[k] = h3[k] >>> mlp_pkg::FRAC_BITS;
      priority if (hsh[k] > mlp_pkg::hsum_t'(mlp_pkg::Q_MAX)) begin
        hsat[k] = mlp_pkg::q_t'(mlp_pkg::Q_MAX);
      end else if (hsh[k] < mlp_pkg::hsum_t'(mlp_pkg::Q_MIN)) begin
        hsat[k] = mlp_pkg::q_t'(mlp_pkg::Q_MIN);
      end else begin
        hsat[k] = hsh[k][mlp_pkg::Q_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < H; k++) begin
      hv4[k] <= hsat[k];
    end
  end

  // stage 5: hidden values times output weights
  always_ff @(posedge clk) begin
    for (int k = 0; k < H; k++) begin
      op5[k] <= mlp_pkg::prod_t'(hv4[k]) * mlp_pkg::prod_t'(w_out[k]);
    end
    ob5 <= w_out[H];
  end

  // stage 6: output sum; it never exceeds 40 bits, so the clamp is a sign extend
  mlp_pkg::osum_t osum;
  always_comb begin
    osum = mlp_pkg::osum_t'(ob5) <<< mlp_pkg::FRAC_BITS;
    for (int k = 0; k < H; k++) begin
      osum = osum + mlp_pkg::osum_t'(op5[k]);
    end
  end

  always_ff @(posedge clk) begin
    activation_sum <= mlp_pkg::sum_t'(osum);
    fires          <= (osum > mlp_pkg::osum_t'(0));
  end

  assign done = v6;

endmodule
`default_nettype wire

// ===== hdl/mlp_chk.sv =====
// port-level checker for the perceptron, bound to the top level
`default_nettype none
module mlp_chk (
  input wire                           clk,
  input wire                           rst,
  input wire                           start,
  input wire                           busy,
  input wire                           mode,
  input wire                           done,
  input wire signed [mlp_pkg::SUM_W-1:0] activation_sum,
  input wire                           fires
);

  logic eval_acc;
  logic wr_acc;
  assign eval_acc = start && !busy && (mode == mlp_pkg::MODE_EVAL);
  assign wr_acc   = start && !busy && (mode == mlp_pkg::MODE_WRITE);

  // every evaluation gives its result after the fixed latency
  a_eval_result: assert property (@(posedge clk) disable iff (rst)
    eval_acc |-> ##(mlp_pkg::LATENCY) done)
    else $error("evaluation result missing");

  // a weight write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    wr_acc |-> ##(mlp_pkg::LATENCY) !done)
    else $error("result produced by weight write");

  // no result without an evaluation that long ago
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(eval_acc, mlp_pkg::LATENCY))
    else $error("result without evaluation");

  // the flag follows the sign of the sum
  a_fires_sign: assert property (@(posedge clk) disable iff (rst)
    done |-> (fires == (!activation_sum[mlp_pkg::SUM_W-1] && activation_sum != '0)))
    else $error("fires disagrees with activation sum");

endmodule

bind mlp_4_5_1_leaky_relu_eval mlp_chk u_mlp_chk (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .mode           (mode),
  .done           (done),
  .activation_sum (activation_sum),
  .fires          (fires)
);
`default_nettype wire
